FILE: src/bfs_pkg.sv
// Bucketed feature selector: shared constants, types and the sort compare.
// Used by bfs_div, the top level and the testbench; depends on nothing.
package bfs_pkg;

  localparam int MAX_CELLS_X = 32;
  localparam int MAX_CELLS_Y = 16;
  localparam int LIST_DEPTH  = 16;
  localparam int ID_WIDTH    = 16;
  localparam int NUM_CLASSES = 4;
  localparam int NUM_CELLS   = MAX_CELLS_X * MAX_CELLS_Y;

  localparam int CELL_W  = $clog2(NUM_CELLS);
  localparam int CLS_W   = $clog2(NUM_CLASSES);
  localparam int RANK_W  = $clog2(LIST_DEPTH);
  localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
  localparam int LIST_W  = CELL_W + CLS_W;
  localparam int ADDR_W  = LIST_W + RANK_W;
  localparam int COORD_W = 12;
  localparam int DCNT_W  = $clog2(COORD_W);
  localparam int SEL_W   = 7;
  localparam int AGE_W   = 8;
  localparam int STR_W   = 16;
  localparam int OID_W   = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_OUTSIDE  = 3'd1;
  localparam logic [2:0] ST_BAD_CLS  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_SELECTED = 3'd4;
  localparam logic [2:0] ST_NONE     = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_IMG_W   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_H   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_THR = 3'd4;

  typedef struct packed {
    logic [ID_WIDTH-1:0]    id;
    logic [AGE_W-1:0]       age;
    logic signed [STR_W-1:0] strength;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] dividend;
    logic [COORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] quot;
    logic [COORD_W-1:0] rem;
  } div_rsp_t;

  // front entry a and back entry b trade places when this is true
  function automatic logic must_swap(entry_t a, entry_t b, logic [AGE_W-1:0] thr);
    logic res;
    if (a.age == b.age || a.age > thr || b.age > thr) begin
      res = (a.strength < b.strength);
    end else begin
      res = (a.age < b.age);
    end
    return res;
  endfunction

endpackage

FILE: src/bfs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bfs_ram #(
  parameter int ADDR_W = 4,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/bfs_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on bfs_pkg.
module bfs_div (
  input  logic               clk,
  input  logic               rst_n,
  input  bfs_pkg::div_req_t  req,
  output bfs_pkg::div_rsp_t  rsp
);
  import bfs_pkg::*;

  logic [COORD_W-1:0] quot_r, rem_r, dvs_r;
  logic [DCNT_W-1:0]  cnt_r;
  logic               busy_r, done_r;
  logic [COORD_W:0]   shin;
  logic [COORD_W+1:0] diff;
  logic               ge;

  always_comb begin
    shin = {rem_r, quot_r[COORD_W-1]};
    diff = {1'b0, shin} - {2'b00, dvs_r};
    ge   = ~diff[COORD_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == DCNT_W'(COORD_W - 1));
      if (req.start) begin
        quot_r <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= ge ? diff[COORD_W-1:0] : shin[COORD_W-1:0];
        quot_r <= {quot_r[COORD_W-2:0], ge};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(COORD_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

FILE: src/bucketed_feature_selector_core.sv
// Bucketed feature selector top level: sequencer, list store and list counts.
// Depends on bfs_pkg, bfs_ram and bfs_div.
//
// Usage: one input word per request on in_* (valid/ready). in_func 0 loads a
// match into its grid cell and class list; in_func 1 pulls the next selected
// match id. Every input word yields exactly one result word on out_*.
// The user must see that config registers are written on cfg_* only while the
// block is idle; the block itself does not enforce this. A load runs four
// divisions through the shared divider plus a count lookup. The first pull of
// a frame sorts every list in passes of compares; each pull then walks cells,
// with four count reads per visited cell.
// One word is in flight at a time; in_ready is low while it is worked on.
// The result register holds a word while out_ready is low; the next word may
// be accepted meanwhile and finishes into the register once it drains.
// Reset, the final pull of a frame and a pull with nothing left start a pass
// clearing all 2048 list counts; no input word is taken then.
module bucketed_feature_selector_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [15:0]                    in_match_id,
  input  logic [11:0]                    in_pos_x,
  input  logic [11:0]                    in_pos_y,
  input  logic [3:0]                     in_feature_class,
  input  logic [7:0]                     in_track_age,
  input  logic signed [15:0]             in_strength,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_status,
  output logic [15:0]                    out_selected_id,
  output logic                           out_last_flag,
  input  logic                           cfg_we,
  input  logic [bfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [11:0]                    cfg_wdata
);
  import bfs_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LD_DW, S_LD_DH, S_LD_DX, S_LD_DY, S_LD_CHK, S_LD_CNT,
    S_SRT_CNT, S_SRT_CNTW, S_SRT_RD0, S_SRT_RD0W, S_SRT_RDB, S_SRT_CMP, S_SRT_END,
    S_SK_TOP, S_SK_LD, S_SK_LDW, S_SEL_RD, S_SEL_RDW, S_OUT
  } state_t;

  // config
  logic [COORD_W-1:0] img_w_r, img_h_r, bucket_r;
  logic [SEL_W-1:0]   max_per_r;
  logic [AGE_W-1:0]   age_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r   <= 12'd1241;
      img_h_r   <= 12'd376;
      bucket_r  <= 12'd50;
      max_per_r <= 7'd4;
      age_thr_r <= 8'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMG_W:   img_w_r   <= cfg_wdata;
        CFG_IMG_H:   img_h_r   <= cfg_wdata;
        CFG_BUCKET:  bucket_r  <= cfg_wdata;
        CFG_MAX_PER: max_per_r <= cfg_wdata[SEL_W-1:0];
        CFG_AGE_THR: age_thr_r <= cfg_wdata[AGE_W-1:0];
        default: ;
      endcase
    end
  end

  state_t             state_r;
  logic               sorted_r, loaded_r, second_r;
  logic [CELL_W:0]    cell_r;
  logic [CNT_W-1:0]   rank_r, depth_r, m_r;
  logic [CLS_W-1:0]   cls_cur_r, k_r;
  logic [SEL_W-1:0]   sel_r;
  logic [CNT_W-1:0]   cc_r [NUM_CLASSES];
  logic [LIST_W-1:0]  list_r, clr_r;
  logic [RANK_W-1:0]  j_r;
  entry_t             cur_r;

  entry_t             ld_ent_r;
  logic [COORD_W-1:0] ld_x_r, ld_y_r, nx_r, ny_r, sx_r, cx_r, cy_r;
  logic [3:0]         ld_cls_r;
  logic [CELL_W-1:0]  ld_cell_r;

  logic [2:0]         res_status_r;
  logic [OID_W-1:0]   res_id_r;
  logic               res_last_r, res_clear_r;
  logic               out_valid_r, out_last_r;
  logic [2:0]         out_status_r;
  logic [OID_W-1:0]   out_id_r;

  div_req_t           div_req_r;
  div_rsp_t           div_rsp;

  logic               cnt_we, st_we;
  logic [LIST_W-1:0]  cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]   cnt_wdata, cnt_rdata;
  logic [ADDR_W-1:0]  st_waddr, st_raddr;
  entry_t             st_wdata, st_rdata;

  logic [COORD_W-1:0] bs;
  logic [SEL_W-1:0]   limit;
  logic               swap;
  logic [COORD_W-1:0] sy_w, nycap_w;

  bfs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  bfs_ram #(.ADDR_W(LIST_W), .DATA_W(CNT_W)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  bfs_ram #(.ADDR_W(ADDR_W), .DATA_W(ENTRY_W)) u_store_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  always_comb begin
    bs      = (bucket_r == '0) ? COORD_W'(1) : bucket_r;
    limit   = (max_per_r == '0) ? SEL_W'(1) : max_per_r;
    swap    = must_swap(cur_r, st_rdata, age_thr_r);
    sy_w    = div_rsp.rem >> 1;
    nycap_w = (div_rsp.quot > COORD_W'(MAX_CELLS_Y)) ? COORD_W'(MAX_CELLS_Y) : div_rsp.quot;

    cnt_we    = 1'b0;
    cnt_waddr = '0;
    cnt_wdata = '0;
    cnt_raddr = '0;
    st_we     = 1'b0;
    st_waddr  = '0;
    st_wdata  = cur_r;
    st_raddr  = '0;
    unique case (state_r)
      S_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
      end
      S_LD_CHK: cnt_raddr = {ld_cell_r, ld_cls_r[CLS_W-1:0]};
      S_LD_CNT: begin
        if (cnt_rdata < CNT_W'(LIST_DEPTH)) begin
          cnt_we    = 1'b1;
          cnt_waddr = {ld_cell_r, ld_cls_r[CLS_W-1:0]};
          cnt_wdata = cnt_rdata + 1'b1;
          st_we     = 1'b1;
          st_waddr  = {ld_cell_r, ld_cls_r[CLS_W-1:0], cnt_rdata[RANK_W-1:0]};
          st_wdata  = ld_ent_r;
        end
      end
      S_SRT_CNT: cnt_raddr = list_r;
      S_SRT_RD0: st_raddr  = {list_r, RANK_W'(0)};
      S_SRT_RDB: st_raddr  = {list_r, j_r + 1'b1};
      S_SRT_CMP: begin
        st_we    = 1'b1;
        st_waddr = {list_r, j_r};
        st_wdata = swap ? st_rdata : cur_r;
      end
      S_SRT_END: begin
        st_we    = 1'b1;
        st_waddr = {list_r, RANK_W'(m_r - 1'b1)};
      end
      S_SK_LD:  cnt_raddr = {cell_r[CELL_W-1:0], k_r};
      S_SEL_RD: st_raddr  = {cell_r[CELL_W-1:0], cls_cur_r, rank_r[RANK_W-1:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      sorted_r    <= 1'b0;
      loaded_r    <= 1'b0;
      second_r    <= 1'b0;
      cell_r      <= '0;
      rank_r      <= '0;
      cls_cur_r   <= '0;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
      div_req_r   <= '0;
    end else begin
      if (div_req_r.start) begin
        div_req_r.start <= 1'b0;
      end
      if (out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            res_id_r    <= '0;
            res_last_r  <= 1'b0;
            res_clear_r <= 1'b0;
            if (!in_func) begin
              ld_ent_r.id       <= ID_WIDTH'(in_match_id);
              ld_ent_r.age      <= in_track_age;
              ld_ent_r.strength <= in_strength;
              ld_x_r            <= in_pos_x;
              ld_y_r            <= in_pos_y;
              ld_cls_r          <= in_feature_class;
              div_req_r         <= '{start: 1'b1, dividend: img_w_r, divisor: bs};
              state_r           <= S_LD_DW;
            end else begin
              second_r <= 1'b0;
              list_r   <= '0;
              state_r  <= sorted_r ? S_SK_TOP : S_SRT_CNT;
            end
          end
        end
        S_LD_DW: begin
          if (div_rsp.done) begin
            nx_r      <= (div_rsp.quot > COORD_W'(MAX_CELLS_X)) ?
                         COORD_W'(MAX_CELLS_X) : div_rsp.quot;
            sx_r      <= div_rsp.rem >> 1;
            div_req_r <= '{start: 1'b1, dividend: img_h_r, divisor: bs};
            state_r   <= S_LD_DH;
          end
        end
        S_LD_DH: begin
          if (div_rsp.done) begin
            ny_r <= nycap_w;
            if (ld_x_r < sx_r || ld_y_r < sy_w) begin
              res_status_r <= ST_OUTSIDE;
              state_r      <= S_OUT;
            end else begin
              cy_r      <= ld_y_r - sy_w;
              div_req_r <= '{start: 1'b1, dividend: ld_x_r - sx_r, divisor: bs};
              state_r   <= S_LD_DX;
            end
          end
        end
        S_LD_DX: begin
          if (div_rsp.done) begin
            cx_r      <= div_rsp.quot;
            div_req_r <= '{start: 1'b1, dividend: cy_r, divisor: bs};
            state_r   <= S_LD_DY;
          end
        end
        S_LD_DY: begin
          if (div_rsp.done) begin
            cy_r      <= div_rsp.quot;
            ld_cell_r <= CELL_W'(cx_r * MAX_CELLS_Y + div_rsp.quot);
            state_r   <= S_LD_CHK;
          end
        end
        S_LD_CHK: begin
          if (cx_r >= nx_r || cy_r >= ny_r) begin
            res_status_r <= ST_OUTSIDE;
            state_r      <= S_OUT;
          end else if (ld_cls_r >= 4'(NUM_CLASSES)) begin
            res_status_r <= ST_BAD_CLS;
            state_r      <= S_OUT;
          end else begin
            state_r <= S_LD_CNT;
          end
        end
        S_LD_CNT: begin
          if (cnt_rdata < CNT_W'(LIST_DEPTH)) begin
            res_status_r <= ST_STORED;
            sorted_r     <= 1'b0;
            loaded_r     <= 1'b0;
            cell_r       <= '0;
            rank_r       <= '0;
            cls_cur_r    <= '0;
            sel_r        <= '0;
          end else begin
            res_status_r <= ST_FULL;
          end
          state_r <= S_OUT;
        end
        S_SRT_CNT: state_r <= S_SRT_CNTW;
        S_SRT_CNTW: begin
          m_r <= cnt_rdata;
          if (cnt_rdata < CNT_W'(2)) begin
            list_r <= list_r + 1'b1;
            if (list_r == '1) begin
              sorted_r  <= 1'b1;
              loaded_r  <= 1'b0;
              cell_r    <= '0;
              rank_r    <= '0;
              cls_cur_r <= '0;
              sel_r     <= '0;
              state_r   <= S_SK_TOP;
            end else begin
              state_r <= S_SRT_CNT;
            end
          end else begin
            state_r <= S_SRT_RD0;
          end
        end
        S_SRT_RD0: begin
          j_r     <= '0;
          state_r <= S_SRT_RD0W;
        end
        S_SRT_RD0W: begin
          cur_r   <= st_rdata;
          state_r <= S_SRT_RDB;
        end
        S_SRT_RDB: state_r <= S_SRT_CMP;
        S_SRT_CMP: begin
          if (!swap) begin
            cur_r <= st_rdata;
          end
          if (CNT_W'(j_r) + CNT_W'(2) == m_r) begin
            state_r <= S_SRT_END;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_SRT_RDB;
          end
        end
        S_SRT_END: begin
          m_r <= m_r - 1'b1;
          if (m_r == CNT_W'(2)) begin
            list_r <= list_r + 1'b1;
            if (list_r == '1) begin
              sorted_r  <= 1'b1;
              loaded_r  <= 1'b0;
              cell_r    <= '0;
              rank_r    <= '0;
              cls_cur_r <= '0;
              sel_r     <= '0;
              state_r   <= S_SK_TOP;
            end else begin
              state_r <= S_SRT_CNT;
            end
          end else begin
            state_r <= S_SRT_RD0;
          end
        end
        S_SK_TOP: begin
          priority if (cell_r == (CELL_W+1)'(NUM_CELLS)) begin
            res_status_r <= second_r ? ST_SELECTED : ST_NONE;
            res_last_r   <= second_r;
            res_clear_r  <= 1'b1;
            state_r      <= S_OUT;
          end else if (!loaded_r) begin
            k_r     <= '0;
            depth_r <= '0;
            state_r <= S_SK_LD;
          end else if (sel_r >= limit || rank_r >= depth_r) begin
            cell_r    <= cell_r + 1'b1;
            rank_r    <= '0;
            cls_cur_r <= '0;
            sel_r     <= '0;
            loaded_r  <= 1'b0;
          end else if (rank_r < cc_r[cls_cur_r]) begin
            if (second_r) begin
              res_status_r <= ST_SELECTED;
              state_r      <= S_OUT;
            end else begin
              state_r <= S_SEL_RD;
            end
          end else begin
            cls_cur_r <= cls_cur_r + 1'b1;
            if (cls_cur_r == CLS_W'(NUM_CLASSES - 1)) begin
              rank_r <= rank_r + 1'b1;
            end
          end
        end
        S_SK_LD: state_r <= S_SK_LDW;
        S_SK_LDW: begin
          cc_r[k_r] <= cnt_rdata;
          if (cnt_rdata > depth_r) begin
            depth_r <= cnt_rdata;
          end
          if (k_r == CLS_W'(NUM_CLASSES - 1)) begin
            loaded_r <= 1'b1;
            state_r  <= S_SK_TOP;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_SK_LD;
          end
        end
        S_SEL_RD: state_r <= S_SEL_RDW;
        S_SEL_RDW: begin
          res_id_r  <= OID_W'(st_rdata.id);
          sel_r     <= sel_r + 1'b1;
          cls_cur_r <= cls_cur_r + 1'b1;
          if (cls_cur_r == CLS_W'(NUM_CLASSES - 1)) begin
            rank_r <= rank_r + 1'b1;
          end
          second_r <= 1'b1;
          state_r  <= S_SK_TOP;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_id_r     <= res_id_r;
            out_last_r   <= res_last_r;
            if (res_clear_r) begin
              clr_r     <= '0;
              sorted_r  <= 1'b0;
              loaded_r  <= 1'b0;
              cell_r    <= '0;
              rank_r    <= '0;
              cls_cur_r <= '0;
              sel_r     <= '0;
              state_r   <= S_CLR;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_selected_id = out_id_r;
  assign out_last_flag   = out_last_r;

`ifndef ASSERT_OFF
  a_last_is_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_status_r == ST_SELECTED)
    else $error("last flag on a word that is not a selection");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_LD_DW || state_r == S_LD_DH ||
                      state_r == S_LD_DX || state_r == S_LD_DY))
    else $error("divider finished outside a load");

  a_store_wr: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> (state_r == S_SRT_CMP || state_r == S_SRT_END || state_r == S_LD_CNT))
    else $error("store written outside sort or load");

  a_cursor_rng: assert property (@(posedge clk) disable iff (!rst_n)
    cell_r <= (CELL_W+1)'(NUM_CELLS))
    else $error("cell cursor out of range");
`endif

endmodule

FILE: dv/bucketed_feature_selector_core_tb.sv
// Testbench for bucketed_feature_selector_core: directed and random loads and pulls,
// checked word by word against a scoreboard holding its own copy of the grid lists.
// Depends on bfs_pkg and the core RTL.
`timescale 1ns / 1ps

module bucketed_feature_selector_core_tb;
  import bfs_pkg::*;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_PULL = 1'b1;
  localparam int   LIMIT     = 20000000;
  localparam int   SETTLE    = 2300;

  typedef struct packed {
    logic               func;
    logic [15:0]        id;
    logic [11:0]        x;
    logic [11:0]        y;
    logic [3:0]         cls;
    logic [7:0]         age;
    logic signed [15:0] str;
  } word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] id;
    logic        last;
  } res_t;

  class selector_scoreboard;
    entry_t      lists[NUM_CELLS][NUM_CLASSES][LIST_DEPTH];
    int unsigned counts[NUM_CELLS][NUM_CLASSES];
    bit          sorted;
    int unsigned cur_cell, cur_rank, cur_cls, cell_sel;
    int unsigned img_w = 1241, img_h = 376, bsize = 50, per_cell = 4, age_thr = 4;
    bit          frame_over;
    res_t        pending_q[$];
    int          errors;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [11:0] v);
      case (idx)
        CFG_IMG_W:   img_w = v;
        CFG_IMG_H:   img_h = v;
        CFG_BUCKET:  bsize = v;
        CFG_MAX_PER: per_cell = v[6:0];
        CFG_AGE_THR: age_thr = v[7:0];
        default: ;
      endcase
    endfunction

    function void restart_cursor();
      cur_cell = 0; cur_rank = 0; cur_cls = 0; cell_sel = 0;
    endfunction

    function void drop_frame();
      foreach (counts[c, k]) counts[c][k] = 0;
      sorted = 0;
      restart_cursor();
    endfunction

    function bit goes_behind(entry_t a, entry_t b);
      if (a.age == b.age || a.age > age_thr || b.age > age_thr) return a.strength < b.strength;
      return a.age < b.age;
    endfunction

    function void bubble_all();
      entry_t t;
      int unsigned n;
      for (int c = 0; c < NUM_CELLS; c++)
        for (int k = 0; k < NUM_CLASSES; k++) begin
          n = counts[c][k];
          for (int i = 0; i < n; i++)
            for (int j = 0; j + i + 1 < n; j++)
              if (goes_behind(lists[c][k][j], lists[c][k][j+1])) begin
                t = lists[c][k][j];
                lists[c][k][j] = lists[c][k][j+1];
                lists[c][k][j+1] = t;
              end
        end
    endfunction

    function bit advance();
      int unsigned lim, deep;
      lim = per_cell ? per_cell : 1;
      while (cur_cell < NUM_CELLS) begin
        deep = 0;
        for (int k = 0; k < NUM_CLASSES; k++)
          if (counts[cur_cell][k] > deep) deep = counts[cur_cell][k];
        if (cell_sel >= lim || cur_rank >= deep) begin
          cur_cell++; cur_rank = 0; cur_cls = 0; cell_sel = 0;
          continue;
        end
        if (cur_rank < counts[cur_cell][cur_cls]) return 1;
        cur_cls++;
        if (cur_cls >= NUM_CLASSES) begin
          cur_cls = 0; cur_rank++;
        end
      end
      return 0;
    endfunction

    function logic [2:0] place_match(word_t w);
      int unsigned bs, sx, sy, nx, ny, cx, cy, c, n;
      bs = bsize ? bsize : 1;
      sx = (img_w % bs) / 2; sy = (img_h % bs) / 2;
      nx = img_w / bs; ny = img_h / bs;
      if (nx > MAX_CELLS_X) nx = MAX_CELLS_X;
      if (ny > MAX_CELLS_Y) ny = MAX_CELLS_Y;
      if (w.x < sx || w.y < sy) return ST_OUTSIDE;
      cx = (w.x - sx) / bs; cy = (w.y - sy) / bs;
      if (cx >= nx || cy >= ny) return ST_OUTSIDE;
      if (w.cls >= NUM_CLASSES) return ST_BAD_CLS;
      c = cx * MAX_CELLS_Y + cy;
      n = counts[c][w.cls];
      if (n >= LIST_DEPTH) return ST_FULL;
      lists[c][w.cls][n] = '{id: w.id, age: w.age, strength: w.str};
      counts[c][w.cls] = n + 1;
      sorted = 0;
      restart_cursor();
      return ST_STORED;
    endfunction

    function void note_word(word_t w);
      res_t r;
      r = '0;
      if (w.func == FUNC_LOAD) begin
        r.status = place_match(w);
        if (r.status == ST_STORED) frame_over = 0;
      end else begin
        if (!sorted) begin
          bubble_all();
          sorted = 1;
          restart_cursor();
        end
        if (!advance()) begin
          drop_frame();
          r.status = ST_NONE;
          frame_over = 1;
        end else begin
          r.status = ST_SELECTED;
          r.id = lists[cur_cell][cur_cls][cur_rank].id;
          cell_sel++;
          cur_cls++;
          if (cur_cls >= NUM_CLASSES) begin
            cur_cls = 0; cur_rank++;
          end
          if (!advance()) begin
            r.last = 1;
            drop_frame();
            frame_over = 1;
          end
        end
      end
      pending_q = {pending_q, r};
    endfunction

    function void check_word(res_t got);
      res_t e;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: %p", got);
        return;
      end
      e = pending_q.pop_front();
      if (got.status !== e.status || got.id !== e.id || got.last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp status %0d id %h last %b, got status %0d id %h last %b",
                   e.status, e.id, e.last, got.status, got.id, got.last);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, in_func;
  logic [15:0] in_match_id;
  logic [11:0] in_pos_x, in_pos_y;
  logic [3:0] in_feature_class;
  logic [7:0] in_track_age;
  logic signed [15:0] in_strength;
  logic out_valid, out_ready;
  logic [2:0] out_status;
  logic [15:0] out_selected_id;
  logic out_last_flag;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [11:0] cfg_wdata;

  selector_scoreboard sb = new();
  int  cycles;
  int  hold_req;
  bit  no_idle;

  bucketed_feature_selector_core dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready)
      sb.check_word('{status: out_status, id: out_selected_id, last: out_last_flag});

  initial begin
    int n;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 12);
      end
      @(negedge clk);
      if (n > 0) begin
        out_ready = 0;
        repeat (n) @(negedge clk);
      end
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send(word_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1;
    {in_func, in_match_id, in_pos_x, in_pos_y, in_feature_class, in_track_age, in_strength} = w;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
  endtask

  task automatic load(logic [15:0] id, logic [11:0] x, logic [11:0] y, logic [3:0] cls,
                      logic [7:0] age, logic signed [15:0] str);
    send('{func: FUNC_LOAD, id: id, x: x, y: y, cls: cls, age: age, str: str});
  endtask

  task automatic pull();
    send('{func: FUNC_PULL, id: 16'($urandom), x: 12'($urandom), y: 12'($urandom),
           cls: 4'($urandom), age: 8'($urandom), str: 16'($urandom)});
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [11:0] v);
    @(negedge clk);
    cfg_we = 1; cfg_index = idx; cfg_wdata = v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic random_load();
    int unsigned bs, sx, sy, nx, ny, cx, cy, r;
    logic [11:0] x, y;
    logic [3:0] cls;
    logic [7:0] age;
    bs = sb.bsize ? sb.bsize : 1;
    sx = (sb.img_w % bs) / 2; sy = (sb.img_h % bs) / 2;
    nx = sb.img_w / bs; ny = sb.img_h / bs;
    if (nx > MAX_CELLS_X) nx = MAX_CELLS_X;
    if (ny > MAX_CELLS_Y) ny = MAX_CELLS_Y;
    r = $urandom_range(0, 99);
    if (nx == 0 || ny == 0 || r < 8) begin
      x = 12'($urandom); y = 12'($urandom);
    end else begin
      cx = (r < 50) ? $urandom_range(0, nx > 2 ? 1 : nx - 1) : $urandom_range(0, nx - 1);
      cy = (r < 50) ? $urandom_range(0, ny > 2 ? 1 : ny - 1) : $urandom_range(0, ny - 1);
      x = 12'(sx + cx * bs + $urandom_range(0, bs - 1));
      y = 12'(sy + cy * bs + $urandom_range(0, bs - 1));
    end
    cls = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
    age = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 8));
    load(16'($urandom), x, y, cls, age, 16'($urandom));
  endtask

  // one frame: a batch of loads, then pulls (plus at most one load) until it ends
  task automatic run_frame(ref int sent);
    int nl, guard;
    bit mid;
    nl = $urandom_range(1, 40);
    repeat (nl) random_load();
    sent += nl;
    mid = 0;
    guard = 0;
    do begin
      if (!mid && $urandom_range(0, 29) == 0) begin
        mid = 1;
        random_load();
      end else begin
        pull();
      end
      sent++;
      guard++;
    end while (!sb.frame_over && guard < 300);
  endtask

  initial begin
    int sent;
    logic [11:0] cfgs[6][5];
    cfgs = '{'{4095, 4095, 1, 64, 255}, '{4095, 4095, 4095, 1, 0},
             '{100, 60, 0, 0, 0}, '{1, 1, 4095, 127, 200},
             '{640, 480, 40, 3, 10}, '{1241, 376, 50, 4, 4}};
    rst_n = 0; in_valid = 0; in_func = 0; in_match_id = 0; in_pos_x = 0; in_pos_y = 0;
    in_feature_class = 0; in_track_age = 0; in_strength = 0;
    cfg_we = 0; cfg_index = '0; cfg_wdata = 0;
    cycles = 0; hold_req = 0; no_idle = 0;
    sb.frame_over = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: reset grid is 24x7 cells starting at (20,13)
    pull();
    load(16'h0000, 0, 0, 0, 0, 0);
    load(16'hffff, 4095, 4095, 15, 255, 16'sh7fff);
    load(16'h1111, 25, 20, 15, 3, 0);
    load(16'h2222, 25, 20, 0, 2, -16'sd32768);
    load(16'h3333, 26, 21, 0, 4, 16'sd100);
    load(16'h4444, 27, 22, 0, 4, 16'sd200);
    load(16'h5555, 28, 23, 0, 9, 16'sh7fff);
    load(16'h6666, 29, 24, 1, 0, 16'sd5);
    load(16'h7777, 30, 25, 2, 255, -16'sd1);
    load(16'h8888, 31, 26, 3, 1, 16'sd7);
    load(16'haaaa, 1219, 361, 3, 8'haa, 16'sh5555);
    load(16'hbbbb, 1220, 100, 2, 8'h55, 16'shaaaa);
    pull();
    pull();
    load(16'hcccc, 40, 40, 1, 2, 16'sd3);
    repeat (12) pull();
    for (int i = 0; i < 17; i++) load(16'(i), 100, 100, 2, 8'(i), 16'(i * 97));
    repeat (5) pull();
    sent = 40;
    drain();

    for (int p = 0; p < 6; p++) begin
      for (int r = 0; r < 5; r++) write_reg(CFG_IDX_W'(r), cfgs[p][r]);
      no_idle = (p == 2);
      if (p == 4) hold_req = 400;
      while (sent < 40 + (p + 1) * 210) run_frame(sent);
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
